@@ hw/rtl/psl_pkg.sv @@
// Package for the peak safety limiter: field widths, register indexes, reset values
// and the command and status structs passed between controller and datapath.
// No dependencies.
package psl_pkg;

    localparam int LevelW   = 20;
    localparam int CoefW    = 24;
    localparam int GainW    = 17;
    localparam int QuotW    = 16;
    localparam int CfgIdxW  = 3;
    localparam int CntW     = 4;
    localparam int ProdW    = 46;

    localparam logic [CfgIdxW-1:0] RegThreshold     = 3'd0;
    localparam logic [CfgIdxW-1:0] RegEnvAttack     = 3'd1;
    localparam logic [CfgIdxW-1:0] RegEnvRelease    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegGainAttack    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegGainRelease   = 3'd4;

    localparam logic [LevelW-1:0] ThresholdRst      = 20'd62259;
    localparam logic [CoefW-1:0]  EnvAttackRst      = 24'd16431190;
    localparam logic [CoefW-1:0]  EnvReleaseRst     = 24'd16773721;
    localparam logic [CoefW-1:0]  GainAttackRst     = 24'd16431190;
    localparam logic [CoefW-1:0]  GainReleaseRst    = 24'd16774303;
    localparam logic [GainW-1:0]  GainUnity         = 17'd65536;
    localparam logic [ProdW-1:0]  RoundHalf         = 46'd8388608;

    typedef struct packed {
        logic load_peak;
        logic sel_gain;
        logic mul_en;
        logic env_upd;
        logic div_start;
        logic div_step;
        logic tgt_unity;
        logic tgt_quot;
        logic gain_upd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic env_gt_thr;
    } t_sts;

endpackage

@@ hw/rtl/psl_datapath.sv @@
// Datapath of the peak safety limiter: configuration registers, envelope and gain
// state, a shared smoothing multiplier and a restoring divider.
// Depends on psl_pkg.
module psl_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psl_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [psl_pkg::CoefW-1:0]      i_cfg_data,
    input  logic [psl_pkg::LevelW-1:0]     i_peak,
    input  psl_pkg::t_cmd                  i_cmd,
    output psl_pkg::t_sts                  o_sts,
    output logic [psl_pkg::GainW-1:0]      o_gain
);

    logic [psl_pkg::LevelW-1:0] r_thr;
    logic [psl_pkg::CoefW-1:0]  r_env_att;
    logic [psl_pkg::CoefW-1:0]  r_env_rel;
    logic [psl_pkg::CoefW-1:0]  r_gain_att;
    logic [psl_pkg::CoefW-1:0]  r_gain_rel;

    logic [psl_pkg::LevelW-1:0] r_peak;
    logic [psl_pkg::LevelW-1:0] r_env;
    logic [psl_pkg::GainW-1:0]  r_gain;
    logic [psl_pkg::GainW-1:0]  r_tgt;
    logic [psl_pkg::LevelW-1:0] r_rem;
    logic [psl_pkg::QuotW-1:0]  r_quot;
    logic signed [psl_pkg::ProdW-1:0] r_prod;
    logic [psl_pkg::GainW-1:0]  r_out;

    logic [psl_pkg::LevelW-1:0] sm_y;
    logic [psl_pkg::LevelW-1:0] sm_x;
    logic [psl_pkg::CoefW-1:0]  sm_c;
    logic signed [psl_pkg::LevelW:0] sm_diff;
    logic signed [psl_pkg::ProdW-1:0] n_prod;
    logic signed [psl_pkg::ProdW-1:0] prod_rnd;
    logic signed [psl_pkg::LevelW+1:0] sm_sum;
    logic [psl_pkg::LevelW-1:0] sm_res;
    logic [psl_pkg::LevelW:0]   div_trial;
    logic                       div_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= psl_pkg::ThresholdRst;
            r_env_att  <= psl_pkg::EnvAttackRst;
            r_env_rel  <= psl_pkg::EnvReleaseRst;
            r_gain_att <= psl_pkg::GainAttackRst;
            r_gain_rel <= psl_pkg::GainReleaseRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psl_pkg::RegThreshold:   r_thr      <= i_cfg_data[psl_pkg::LevelW-1:0];
                psl_pkg::RegEnvAttack:   r_env_att  <= i_cfg_data;
                psl_pkg::RegEnvRelease:  r_env_rel  <= i_cfg_data;
                psl_pkg::RegGainAttack:  r_gain_att <= i_cfg_data;
                psl_pkg::RegGainRelease: r_gain_rel <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (i_cmd.sel_gain) begin
            sm_y = {3'b000, r_gain};
            sm_x = {3'b000, r_tgt};
            sm_c = (r_tgt < r_gain) ? r_gain_att : r_gain_rel;
        end else begin
            sm_y = r_env;
            sm_x = r_peak;
            sm_c = (r_peak > r_env) ? r_env_att : r_env_rel;
        end
    end

    // The smoother is rewritten as x + round(c * (y - x) / 2^24), one multiply.
    assign sm_diff  = $signed({1'b0, sm_y}) - $signed({1'b0, sm_x});
    assign n_prod   = $signed({1'b0, sm_c}) * sm_diff;
    assign prod_rnd = (r_prod + $signed(psl_pkg::RoundHalf)) >>> psl_pkg::CoefW;
    assign sm_sum   = $signed({2'b00, sm_x}) + prod_rnd[psl_pkg::LevelW+1:0];
    assign sm_res   = sm_sum[psl_pkg::LevelW-1:0];

    assign div_trial = {r_rem, 1'b0};
    assign div_fit   = (div_trial >= {1'b0, r_env});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env  <= '0;
            r_gain <= psl_pkg::GainUnity;
        end else begin
            if (i_cmd.env_upd) begin
                r_env <= sm_res;
            end
            if (i_cmd.gain_upd) begin
                r_gain <= sm_res[psl_pkg::GainW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_peak) begin
            r_peak <= i_peak;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.div_start) begin
            r_rem  <= r_thr;
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= div_fit ? (div_trial[psl_pkg::LevelW-1:0] - r_env)
                              : div_trial[psl_pkg::LevelW-1:0];
            r_quot <= {r_quot[psl_pkg::QuotW-2:0], div_fit};
        end
        if (i_cmd.tgt_unity) begin
            r_tgt <= psl_pkg::GainUnity;
        end else if (i_cmd.tgt_quot) begin
            r_tgt <= {1'b0, r_quot};
        end
        if (i_cmd.out_load) begin
            r_out <= r_gain;
        end
    end

    assign o_sts.env_gt_thr = (r_env > r_thr);
    assign o_gain           = r_out;

endmodule

@@ hw/rtl/psl_ctrl.sv @@
// Controller of the peak safety limiter: sequences the envelope update, the
// division, the gain update and the output handshake. Depends on psl_pkg.
module psl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  psl_pkg::t_sts  i_sts,
    output psl_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] StIdle    = 4'd0;
    localparam logic [3:0] StEnvMul  = 4'd1;
    localparam logic [3:0] StEnvUpd  = 4'd2;
    localparam logic [3:0] StDivChk  = 4'd3;
    localparam logic [3:0] StDivRun  = 4'd4;
    localparam logic [3:0] StDivEnd  = 4'd5;
    localparam logic [3:0] StGainMul = 4'd6;
    localparam logic [3:0] StGainUpd = 4'd7;
    localparam logic [3:0] StOut     = 4'd8;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic [psl_pkg::CntW-1:0]  r_cnt;
    logic [psl_pkg::CntW-1:0]  n_cnt;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      out_space;

    assign out_space = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            StIdle: begin
                if (i_in_valid) begin
                    o_cmd.load_peak = 1'b1;
                    n_state = StEnvMul;
                end
            end
            StEnvMul: begin
                o_cmd.mul_en = 1'b1;
                n_state = StEnvUpd;
            end
            StEnvUpd: begin
                o_cmd.env_upd = 1'b1;
                n_state = StDivChk;
            end
            StDivChk: begin
                o_cmd.div_start = 1'b1;
                n_cnt = '0;
                if (i_sts.env_gt_thr) begin
                    n_state = StDivRun;
                end else begin
                    o_cmd.tgt_unity = 1'b1;
                    n_state = StGainMul;
                end
            end
            StDivRun: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = StDivEnd;
                end
            end
            StDivEnd: begin
                o_cmd.tgt_quot = 1'b1;
                n_state = StGainMul;
            end
            StGainMul: begin
                o_cmd.sel_gain = 1'b1;
                o_cmd.mul_en   = 1'b1;
                n_state = StGainUpd;
            end
            StGainUpd: begin
                o_cmd.sel_gain = 1'b1;
                o_cmd.gain_upd = 1'b1;
                n_state = StOut;
            end
            StOut: begin
                if (out_space) begin
                    o_cmd.out_load = 1'b1;
                    n_state = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != StIdle);
    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/peak_safety_limiter_core.sv @@
// Peak safety limiter: takes one peak magnitude per transaction and returns the
// smoothed limiter gain. The input channel is i_in_valid / o_in_stall with i_peak,
// the output channel is o_out_valid / i_out_stall with o_gain.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data, which the
// user must do only while idle (not enforced by the block): 0 threshold, 1 and 2
// envelope attack and release, 3 and 4 gain attack and release. Each input
// transaction produces exactly one output transaction. An input is taken only
// while the controller is idle. When the envelope is below or at the threshold the
// target gain is unity; otherwise the 16-step restoring divider computes it as the
// threshold over the envelope. A new input can be taken the cycle after the result
// is loaded, so a new peak is not taken before the last one is through.
// The result sits in an output register; the next item is processed meanwhile and
// waits only at the final step if the receiver still stalls the previous result.
// Reset clears the envelope to zero, sets the gain to unity, loads the register
// defaults and clears the output valid flag; the output gain register is not reset.
// Depends on psl_pkg, psl_ctrl and psl_datapath.
module peak_safety_limiter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psl_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [psl_pkg::CoefW-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [psl_pkg::LevelW-1:0]    i_peak,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [psl_pkg::GainW-1:0]     o_gain
);

    psl_pkg::t_cmd cmd;
    psl_pkg::t_sts sts;

    psl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    psl_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_peak     (i_peak),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_gain     (o_gain)
    );

endmodule
